FILE: hdl/bbo_pkg.sv
// shared types, constants and helper functions for the box pair overlap test
package bbo_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int SIN_LAT    = 10;
  localparam int TRIG_FRAC  = 28;

  localparam logic [30:0] ONE_Q30 = 31'(1) << 30;

  localparam logic [30:0] SIN_COEF [7] = '{
    31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995,
    31'd172272, 31'd3864, 31'd61
  };

  typedef struct packed {
    logic signed [31:0] a_center_x;
    logic signed [31:0] a_center_y;
    logic        [31:0] a_size_x;
    logic        [31:0] a_size_y;
    logic        [15:0] a_angle;
    logic               a_rotatable;
    logic signed [31:0] b_center_x;
    logic signed [31:0] b_center_y;
    logic        [31:0] b_size_x;
    logic        [31:0] b_size_y;
    logic        [15:0] b_angle;
    logic               b_rotatable;
  } bbo_in_t;

  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic        [31:0] asx;
    logic        [31:0] asy;
    logic        [31:0] bsx;
    logic        [31:0] bsy;
    logic               rot;
  } bbo_side_t;

  typedef struct packed {
    logic signed [29:0] ca;
    logic signed [29:0] sa;
    logic signed [29:0] cb;
    logic signed [29:0] sb;
    logic        [28:0] cd;
    logic        [28:0] sd;
  } bbo_trig_t;

  // unsigned q30 product, scaled back to q30
  function automatic logic [31:0] mulsh30(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = a * b;
    return p[61:30];
  endfunction

endpackage

FILE: hdl/bbo_in_if.sv
// input channel carrying one box pair per transaction
interface bbo_in_if;
  logic            valid;
  logic            ready;
  bbo_pkg::bbo_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/bbo_out_if.sv
// output channel carrying one hit bit per transaction
interface bbo_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, output hit, input ready);
  modport sink (input valid, input hit, output ready);
endinterface

FILE: hdl/bbo_sin.sv
// pipelined fixed point sine, odd polynomial on a quarter wave, q28 result
module bbo_sin (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [bbo_pkg::ANGLE_BITS-1:0]     angle_i,
  output logic signed [29:0]                 sin_o,
  output logic [28:0]                        mag_o
);

  localparam int AW = bbo_pkg::ANGLE_BITS;

  logic [1:0]    quad;
  logic [30:0]   t0;
  logic [30:0]   t;
  logic [31:0]   t2_full;
  logic [31:0]   m_full;
  logic [30:0]   m_clamp;
  logic [31:0]   rnd;
  logic [28:0]   mag;

  logic [30:0]   t_q   [1:8];
  logic          neg_q [1:9];
  logic [30:0]   t2_q  [2:7];
  logic [30:0]   h_q   [3:8];
  logic [30:0]   m_q;
  logic signed [29:0] sin_q;
  logic [28:0]   mag_q;

  assign quad = angle_i[AW-1:AW-2];
  assign t0   = 31'(angle_i[AW-3:0]) << (32 - AW);
  assign t    = quad[0] ? (bbo_pkg::ONE_Q30 - t0) : t0;

  assign t2_full = bbo_pkg::mulsh30(t_q[1], t_q[1]);
  assign m_full  = bbo_pkg::mulsh30(h_q[8], t_q[8]);
  assign m_clamp = (m_full > 32'(bbo_pkg::ONE_Q30)) ? bbo_pkg::ONE_Q30 : m_full[30:0];
  assign rnd     = 32'(m_q) + 32'd2;
  assign mag     = rnd[30:2];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q[1]   <= t;
      neg_q[1] <= quad[1];
      for (int k = 2; k <= 8; k++) begin
        t_q[k] <= t_q[k-1];
      end
      for (int k = 2; k <= 9; k++) begin
        neg_q[k] <= neg_q[k-1];
      end
      t2_q[2] <= t2_full[30:0];
      for (int k = 3; k <= 7; k++) begin
        t2_q[k] <= t2_q[k-1];
      end
      m_q   <= m_clamp;
      mag_q <= mag;
      sin_q <= neg_q[9] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  // horner steps, one multiply per stage
  for (genvar j = 0; j < 6; j++) begin : g_horner
    logic [30:0] prev;
    logic [31:0] prod;
    logic [31:0] diff;
    if (j == 0) begin : g_first
      assign prev = bbo_pkg::SIN_COEF[6];
    end else begin : g_next
      assign prev = h_q[2+j];
    end
    assign prod = bbo_pkg::mulsh30(prev, t2_q[2+j]);
    assign diff = 32'(bbo_pkg::SIN_COEF[5-j]) - prod;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        h_q[3+j] <= diff[30:0];
      end
    end
  end

  assign sin_o = sin_q;
  assign mag_o = mag_q;

endmodule

FILE: hdl/bbo_sat.sv
// separating axis and axis aligned tests, products, sums, magnitudes, compare
module bbo_sat (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  bbo_pkg::bbo_side_t side_i,
  input  bbo_pkg::bbo_trig_t trig_i,
  output logic               valid_o,
  output logic               hit_o
);

  logic signed [62:0] pp [8];
  logic        [60:0] sq [8];
  logic        [32:0] adx;
  logic        [32:0] ady;
  logic               aabb;

  logic signed [62:0] pp_q [8];
  logic        [60:0] sq_q [8];
  logic        [31:0] asx_q, asy_q, bsx_q, bsy_q;
  logic               rot_q [1:3];
  logic               aabb_q [1:3];
  logic               vld_q [1:4];

  logic signed [63:0] pr [4];
  logic        [61:0] z [4];
  logic signed [63:0] pr_q [4];
  logic        [61:0] z_q [2:3][4];
  logic        [62:0] ab [4];
  logic        [62:0] ab_q [4];
  logic        [3:0]  sep;
  logic               hit_q;

  always_comb begin
    pp[0] = side_i.dx * trig_i.ca;
    pp[1] = side_i.dy * trig_i.sa;
    pp[2] = side_i.dy * trig_i.ca;
    pp[3] = side_i.dx * trig_i.sa;
    pp[4] = side_i.dx * trig_i.cb;
    pp[5] = side_i.dy * trig_i.sb;
    pp[6] = side_i.dy * trig_i.cb;
    pp[7] = side_i.dx * trig_i.sb;
    sq[0] = side_i.bsx * trig_i.cd;
    sq[1] = side_i.bsy * trig_i.sd;
    sq[2] = side_i.bsx * trig_i.sd;
    sq[3] = side_i.bsy * trig_i.cd;
    sq[4] = side_i.asx * trig_i.cd;
    sq[5] = side_i.asy * trig_i.sd;
    sq[6] = side_i.asx * trig_i.sd;
    sq[7] = side_i.asy * trig_i.cd;
    adx  = side_i.dx[32] ? 33'(-side_i.dx) : 33'(side_i.dx);
    ady  = side_i.dy[32] ? 33'(-side_i.dy) : 33'(side_i.dy);
    aabb = ({adx[31:0], 1'b0} <= 33'(side_i.asx) + 33'(side_i.bsx)) &&
           ({ady[31:0], 1'b0} <= 33'(side_i.asy) + 33'(side_i.bsy));
  end

  always_comb begin
    pr[0] = 64'(pp_q[0]) + 64'(pp_q[1]);
    pr[1] = 64'(pp_q[2]) - 64'(pp_q[3]);
    pr[2] = 64'(pp_q[4]) + 64'(pp_q[5]);
    pr[3] = 64'(pp_q[6]) - 64'(pp_q[7]);
    z[0]  = (62'(asx_q) << bbo_pkg::TRIG_FRAC) + 62'(sq_q[0]) + 62'(sq_q[1]);
    z[1]  = (62'(asy_q) << bbo_pkg::TRIG_FRAC) + 62'(sq_q[2]) + 62'(sq_q[3]);
    z[2]  = (62'(bsx_q) << bbo_pkg::TRIG_FRAC) + 62'(sq_q[4]) + 62'(sq_q[5]);
    z[3]  = (62'(bsy_q) << bbo_pkg::TRIG_FRAC) + 62'(sq_q[6]) + 62'(sq_q[7]);
    for (int i = 0; i < 4; i++) begin
      ab[i]  = pr_q[i][63] ? 63'(-pr_q[i]) : 63'(pr_q[i]);
      sep[i] = {ab_q[i], 1'b0} >= {2'b00, z_q[3][i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q      <= pp;
      sq_q      <= sq;
      asx_q     <= side_i.asx;
      asy_q     <= side_i.asy;
      bsx_q     <= side_i.bsx;
      bsy_q     <= side_i.bsy;
      rot_q[1]  <= side_i.rot;
      aabb_q[1] <= aabb;
      pr_q      <= pr;
      z_q[2]    <= z;
      ab_q      <= ab;
      z_q[3]    <= z_q[2];
      for (int k = 2; k <= 3; k++) begin
        rot_q[k]  <= rot_q[k-1];
        aabb_q[k] <= aabb_q[k-1];
      end
      hit_q <= rot_q[3] ? ~(|sep) : aabb_q[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= 4; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[1] <= valid_i;
      for (int k = 2; k <= 4; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[4];
  assign hit_o   = hit_q;

endmodule

FILE: hdl/bbo_skid.sv
// output register with a skid entry so the pipeline keeps moving under backpressure until the skid entry fills
module bbo_skid (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  logic hit_i,
  output logic en_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic out_hit_o
);

  logic out_vld_q, out_vld_d;
  logic out_hit_q, out_hit_d;
  logic skd_vld_q, skd_vld_d;
  logic skd_hit_q, skd_hit_d;

  always_comb begin
    out_vld_d = out_vld_q;
    out_hit_d = out_hit_q;
    skd_vld_d = skd_vld_q;
    skd_hit_d = skd_hit_q;
    if (!skd_vld_q) begin
      if (!out_vld_q || out_ready_i) begin
        out_vld_d = valid_i;
        out_hit_d = hit_i;
      end else if (valid_i) begin
        skd_vld_d = 1'b1;
        skd_hit_d = hit_i;
      end
    end else if (out_ready_i) begin
      out_vld_d = 1'b1;
      out_hit_d = skd_hit_q;
      skd_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skd_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      skd_vld_q <= skd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_hit_q <= out_hit_d;
    skd_hit_q <= skd_hit_d;
  end

  assign en_o        = ~skd_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_hit_o   = out_hit_q;

endmodule

FILE: hdl/box_box_overlap_test_top.sv
// box pair overlap test: oriented separating axis test or axis aligned test
// throughput: one transaction per cycle while the skid entry is empty, set by the sine pipelines and product stage
// the whole pipeline advances together and holds only once the skid entry is full
// reset clears all valid bits and the output stage, payload registers are not reset
module box_box_overlap_test_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  bbo_in_if.sink    in_i,
  bbo_out_if.source out_o
);

  localparam int AW = bbo_pkg::ANGLE_BITS;
  localparam int SL = bbo_pkg::SIN_LAT;
  localparam logic [AW-1:0] QUARTER = AW'(1) << (AW - 2);

  logic               pipe_en;
  logic [AW-1:0]      ang_a, ang_b, ang_r;
  bbo_pkg::bbo_side_t side;
  bbo_pkg::bbo_side_t side_q [SL];
  logic               vld_q  [SL];
  bbo_pkg::bbo_trig_t trig;
  logic               sat_valid;
  logic               sat_hit;

  assign in_i.ready = pipe_en;

  assign ang_a = AW'(in_i.data.a_angle);
  assign ang_b = AW'(in_i.data.b_angle);
  assign ang_r = ang_b - ang_a;

  always_comb begin
    side.dx  = 33'(in_i.data.b_center_x) - 33'(in_i.data.a_center_x);
    side.dy  = 33'(in_i.data.b_center_y) - 33'(in_i.data.a_center_y);
    side.asx = in_i.data.a_size_x;
    side.asy = in_i.data.a_size_y;
    side.bsx = in_i.data.b_size_x;
    side.bsy = in_i.data.b_size_y;
    side.rot = in_i.data.a_rotatable | in_i.data.b_rotatable;
  end

  bbo_sin u_cos_a (.clk_i, .en_i(pipe_en), .angle_i(ang_a + QUARTER),
                   .sin_o(trig.ca), .mag_o());
  bbo_sin u_sin_a (.clk_i, .en_i(pipe_en), .angle_i(ang_a),
                   .sin_o(trig.sa), .mag_o());
  bbo_sin u_cos_b (.clk_i, .en_i(pipe_en), .angle_i(ang_b + QUARTER),
                   .sin_o(trig.cb), .mag_o());
  bbo_sin u_sin_b (.clk_i, .en_i(pipe_en), .angle_i(ang_b),
                   .sin_o(trig.sb), .mag_o());
  bbo_sin u_cos_r (.clk_i, .en_i(pipe_en), .angle_i(ang_r + QUARTER),
                   .sin_o(), .mag_o(trig.cd));
  bbo_sin u_sin_r (.clk_i, .en_i(pipe_en), .angle_i(ang_r),
                   .sin_o(), .mag_o(trig.sd));

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      side_q[0] <= side;
      for (int k = 1; k < SL; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SL; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (pipe_en) begin
      vld_q[0] <= in_i.valid;
      for (int k = 1; k < SL; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  bbo_sat u_sat (
    .clk_i,
    .rst_ni,
    .en_i    (pipe_en),
    .valid_i (vld_q[SL-1]),
    .side_i  (side_q[SL-1]),
    .trig_i  (trig),
    .valid_o (sat_valid),
    .hit_o   (sat_hit)
  );

  bbo_skid u_skid (
    .clk_i,
    .rst_ni,
    .valid_i     (sat_valid),
    .hit_i       (sat_hit),
    .en_o        (pipe_en),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_hit_o   (out_o.hit)
  );

  // the skid entry only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |-> out_o.valid)
    else $error("skid entry holds a result while the output stage is empty");

  // a finished result meeting a stalled output parks in the skid entry
  a_skid_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_en && sat_valid && out_o.valid && !out_o.ready) |=> !pipe_en)
    else $error("finished result not captured under backpressure");

  // a taken result with nothing behind it leaves the output empty
  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_en && !sat_valid && out_o.valid && out_o.ready) |=> !out_o.valid)
    else $error("result repeated after its transaction");

endmodule

FILE: verif/box_box_overlap_test_top_tb.sv
// self-checking testbench for the box pair overlap test: directed table, random pairs, stalls
module box_box_overlap_test_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 14;
  localparam int RANDOM_PAIRS = 1400;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef struct {
    bbo_pkg::bbo_in_t pair;
    logic             known;
    logic             hit;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bbo_in_if in_ch ();
  bbo_out_if out_ch ();

  box_box_overlap_test_top u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic        hit_q[$];
  int          errors = 0;
  longint      cycles = 0;
  int          send_idle_pct = 7;
  int          recv_idle_pct = 73;
  int          hold_off = 0;
  logic        hold_start = 1'b0;
  logic        hold_used = 1'b0;
  stim_row_t   table_rows[$];

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  function automatic logic [63:0] sine_quarter(input logic [63:0] t);
    logic [63:0] coef[7];
    logic [63:0] t2, s;
    coef = '{64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995,
             64'd172272, 64'd3864, 64'd61};
    t2 = (t * t) >> 30;
    s = coef[6];
    for (int k = 5; k >= 0; k--) s = coef[k] - ((s * t2) >> 30);
    s = (s * t) >> 30;
    return (s > Q30_ONE) ? Q30_ONE : s;
  endfunction

  function automatic longint sine_q28(input logic [63:0] ang);
    logic [63:0] a, t, mag;
    logic [1:0]  quad;
    a = ang & ((64'd1 << bbo_pkg::ANGLE_BITS) - 1);
    quad = a[bbo_pkg::ANGLE_BITS-1 -: 2];
    t = (a & ((64'd1 << (bbo_pkg::ANGLE_BITS - 2)) - 1)) << (32 - bbo_pkg::ANGLE_BITS);
    if (quad[0]) t = Q30_ONE - t;
    mag = (sine_quarter(t) + 2) >> 2;
    return quad[1] ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint cosine_q28(input logic [63:0] ang);
    return sine_q28(ang + (64'd1 << (bbo_pkg::ANGLE_BITS - 2)));
  endfunction

  function automatic longint mag64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic boxes_overlap(input bbo_pkg::bbo_in_t p);
    longint dx, dy, asx, asy, bsx, bsy, ca, sa, cb, sb, cd, sd, one;
    logic [63:0] rel;
    logic sep;
    dx = longint'(p.b_center_x) - longint'(p.a_center_x);
    dy = longint'(p.b_center_y) - longint'(p.a_center_y);
    asx = longint'({32'd0, p.a_size_x});
    asy = longint'({32'd0, p.a_size_y});
    bsx = longint'({32'd0, p.b_size_x});
    bsy = longint'({32'd0, p.b_size_y});
    if (p.a_rotatable || p.b_rotatable) begin
      ca = cosine_q28(p.a_angle);
      sa = sine_q28(p.a_angle);
      cb = cosine_q28(p.b_angle);
      sb = sine_q28(p.b_angle);
      rel = 64'(p.b_angle) - 64'(p.a_angle);
      cd = mag64(cosine_q28(rel));
      sd = mag64(sine_q28(rel));
      one = 64'sd1 << 28;
      sep = (2 * mag64(dx * ca + dy * sa) >= asx * one + bsx * cd + bsy * sd) ||
            (2 * mag64(dy * ca - dx * sa) >= asy * one + bsx * sd + bsy * cd) ||
            (2 * mag64(dx * cb + dy * sb) >= bsx * one + asx * cd + asy * sd) ||
            (2 * mag64(dy * cb - dx * sb) >= bsy * one + asx * sd + asy * cd);
      return !sep;
    end
    return (2 * mag64(dx) <= asx + bsx) && (2 * mag64(dy) <= asy + bsy);
  endfunction

  function automatic bbo_pkg::bbo_in_t make_pair(input int ax, ay,
                                                 input logic [31:0] asx, asy,
                                                 input logic [15:0] aa, input logic ar,
                                                 input int bx, by,
                                                 input logic [31:0] bsx, bsy,
                                                 input logic [15:0] ba, input logic br);
    bbo_pkg::bbo_in_t p;
    p = '{ax, ay, asx, asy, aa, ar, bx, by, bsx, bsy, ba, br};
    return p;
  endfunction

  function automatic logic [31:0] rand32();
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_coord(input int spread);
    case ($urandom_range(0, 9))
      0: return rand32();
      1: return 32'h8000_0000 | $urandom_range(0, 3);
      2: return 32'h7fff_ffff - $urandom_range(0, 3);
      default: return 32'(int'($urandom_range(0, 2 * spread)) - spread);
    endcase
  endfunction

  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 9))
      0: return rand32();
      1: return 32'd0;
      2: return 32'hffff_ffff;
      default: return 32'($urandom_range(0, 32'h0008_0000));
    endcase
  endfunction

  function automatic bbo_pkg::bbo_in_t random_pair();
    bbo_pkg::bbo_in_t p;
    int spread;
    spread = ($urandom_range(0, 3) == 0) ? 32'h0100_0000 : 32'h0008_0000;
    p.a_center_x = rand_coord(spread);
    p.a_center_y = rand_coord(spread);
    p.a_size_x = rand_size();
    p.a_size_y = rand_size();
    p.a_angle = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 3) << 14) : 16'($urandom);
    p.a_rotatable = ($urandom_range(0, 2) != 0);
    p.b_center_x = p.a_center_x + (($urandom_range(0, 3) == 0) ? rand32() :
                   32'(int'($urandom_range(0, 2 * spread)) - spread));
    p.b_center_y = p.a_center_y + (($urandom_range(0, 3) == 0) ? rand32() :
                   32'(int'($urandom_range(0, 2 * spread)) - spread));
    p.b_size_x = rand_size();
    p.b_size_y = rand_size();
    p.b_angle = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 3) << 14) : 16'($urandom);
    p.b_rotatable = ($urandom_range(0, 2) != 0);
    return p;
  endfunction

  task automatic add_row(input bbo_pkg::bbo_in_t p, input logic known, input logic hit);
    stim_row_t r;
    r.pair = p;
    r.known = known;
    r.hit = hit;
    table_rows.push_back(r);
  endtask

  task automatic send_pair(input bbo_pkg::bbo_in_t p, input logic known, input logic hit);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= p;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (known && boxes_overlap(p) !== hit)
      report_mismatch($sformatf("predictor disagrees with table row hit=%0b", hit));
    hit_q.push_back(known ? hit : boxes_overlap(p));
  endtask

  // receiver side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (hit_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          logic exp_hit;
          exp_hit = hit_q.pop_front();
          if (out_ch.hit !== exp_hit)
            report_mismatch($sformatf("hit got %b want %b", out_ch.hit, exp_hit));
        end
      end
      if (hold_start && !hold_used) begin
        hold_used <= 1'b1;
        hold_off <= 200;
        out_ch.ready <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    // touching and disjoint axis-aligned boxes
    add_row(make_pair(0, 0, 32'h2_0000, 32'h2_0000, 0, 0,
                      32'h2_0000, 0, 32'h2_0000, 32'h2_0000, 0, 0), 1, 1);
    add_row(make_pair(0, 0, 32'h2_0000, 32'h2_0000, 0, 0,
                      32'h2_0001, 0, 32'h2_0000, 32'h2_0000, 0, 0), 1, 0);
    add_row(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1);
    // zero sizes under oriented test count as separated
    add_row(make_pair(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0), 1, 0);
    add_row(make_pair(0, 0, 0, 0, 16'h2000, 0, 0, 0, 0, 0, 16'h6000, 1), 1, 0);
    // far apart centers must not wrap
    add_row(make_pair(32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff, 0, 0,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0), 1, 1);
    add_row(make_pair(32'h8000_0000, 0, 32'h1_0000, 32'h1_0000, 0, 0,
                      32'h7fff_ffff, 0, 32'h1_0000, 32'h1_0000, 0, 0), 1, 0);
    add_row(make_pair(32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 1,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'h8000, 1),
            0, 0);
    add_row(make_pair(0, 0, 32'h4_0000, 32'h4_0000, 0, 1,
                      32'h1_0000, 0, 32'h4_0000, 32'h4_0000, 0, 1), 1, 1);
    add_row(make_pair(0, 0, 32'h4_0000, 32'h1_0000, 16'h2000, 1,
                      32'h3_0000, 32'h3_0000, 32'h1_0000, 32'h1_0000, 16'hc000, 0), 0, 0);
    for (int q = 0; q < 4; q++)
      add_row(make_pair(0, 0, 32'h4_0000, 32'h1_0000, 16'(q << 14), 1,
                        0, 32'h1_8000, 32'h2_0000, 32'h1_0000, 16'(16'h4000 - (q << 14)), 0),
              0, 0);
    add_row(make_pair(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0, 16'h7fff, 1,
                      32'h8000_0000, 32'h7fff_ffff, 0, 32'hffff_ffff, 16'h0001, 1), 0, 0);
    add_row(make_pair(32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 16'haaaa, 1,
                      32'haaaa_aaaa, 32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 16'h5555, 1),
            0, 0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i]) send_pair(table_rows[i].pair, table_rows[i].known, table_rows[i].hit);

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n == RANDOM_PAIRS / 3) begin
        send_idle_pct = 73;
        recv_idle_pct = 7;
      end
      if (n == RANDOM_PAIRS / 2) hold_start = 1'b1;
      if (n == 2 * RANDOM_PAIRS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_pair(random_pair(), 0, 0);
    end
    in_ch.valid <= 1'b0;

    while (hit_q.size() != 0) @(posedge clk_i);
    repeat (4 * LATENCY) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

FILE: box_box_overlap_test_top.f
hdl/bbo_pkg.sv
hdl/bbo_in_if.sv
hdl/bbo_out_if.sv
hdl/bbo_sin.sv
hdl/bbo_sat.sv
hdl/bbo_skid.sv
hdl/box_box_overlap_test_top.sv
verif/box_box_overlap_test_top_tb.sv
